### hw/rtl/uuencode_line_encoder_assert.svh
// assertion macros for the line encoder
`ifndef UUENCODE_LINE_ENCODER_ASSERT_SVH
`define UUENCODE_LINE_ENCODER_ASSERT_SVH
`ifndef SYNTH
`define UULE_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("uule check failed");
`define UULE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("uule check failed");
`else
`define UULE_ASSERT_IMPLY(label, ante, cons)
`define UULE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### hw/rtl/uule_pkg.sv
// shared types and constants of the line encoder
package uule_pkg;

  localparam logic       KindStart   = 1'b0;
  localparam logic       KindByte    = 1'b1;
  localparam logic [7:0] CharOffset  = 8'd32;
  localparam logic [7:0] NewlineChar = 8'd10;
  localparam int         QueueDepth  = 2;

  typedef enum logic {
    JOB_LEN   = 1'b0,
    JOB_GROUP = 1'b1
  } job_mode_e;

  typedef struct packed {
    job_mode_e   mode;
    logic [23:0] group;
    logic        nl;
  } job_t;

endpackage

### hw/rtl/uuencode_line_encoder.sv
// top level of the uuencode line encoder
//
// input channel: in_valid_i / in_stall_o with kind_i, line_length_i, data_byte_i.
// a start item (kind 0) opens a line and yields its length character; a length
// above MAX_LINE_BYTES is clamped, and a zero length also yields a newline with
// line_end_o set. data items (kind 1) are packed three to a group, each group
// yields four characters; the line's last byte flushes its group, zero padded if
// short, and a newline with line_end_o set. bytes with no open line are dropped.
// output channel: out_valid_o / out_stall_i with out_char_o, line_end_o.
// throughput: the front end takes one item per cycle while the two-entry job
// queue has room; the back end sends one character per cycle while the receiver
// does not stall, so a long line is paced by the output register.
// a stalled receiver holds the output register; the queue then fills and
// in_stall_o rises until a job drains.
// reset: no line is open, the queue is empty and no output is valid.
`include "uuencode_line_encoder_assert.svh"

module uuencode_line_encoder import uule_pkg::*; #(
  parameter int MAX_LINE_BYTES = 45
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       kind_i,
  input  logic [5:0] line_length_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       line_end_o
);

  logic q_push, q_pop, q_full, q_empty;
  job_t q_job, q_head;

  uule_front #(
    .MAX_LINE_BYTES(MAX_LINE_BYTES)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .kind_i,
    .line_length_i,
    .data_byte_i,
    .q_full_i (q_full),
    .push_o   (q_push),
    .job_o    (q_job)
  );

  uule_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (q_push),
    .job_i   (q_job),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  uule_back u_back (
    .clk_i,
    .rst_ni,
    .q_empty_i (q_empty),
    .head_i    (q_head),
    .pop_o     (q_pop),
    .out_valid_o,
    .out_stall_i,
    .out_char_o,
    .line_end_o
  );

  `UULE_ASSERT_IMPLY(a_no_overflow, q_push, !q_full)
  `UULE_ASSERT_IMPLY(a_no_underflow, q_pop, !q_empty)
  `UULE_ASSERT_IMPLY(a_end_is_newline, out_valid_o && line_end_o, out_char_o == NewlineChar)
  `UULE_ASSERT_IMPLY(a_char_range, out_valid_o && !line_end_o,
                     out_char_o >= 8'd32 && out_char_o <= 8'd95)

endmodule

### hw/rtl/uule_front.sv
// front end: accepts items, packs bytes into groups and issues jobs
module uule_front import uule_pkg::*; #(
  parameter int MAX_LINE_BYTES = 45
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       kind_i,
  input  logic [5:0] line_length_i,
  input  logic [7:0] data_byte_i,
  input  logic       q_full_i,
  output logic       push_o,
  output job_t       job_o
);

  localparam logic [5:0] MaxLen = 6'(MAX_LINE_BYTES);

  logic [15:0] pending_q, pending_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [5:0]  left_q, left_d;
  logic        accept;
  logic [5:0]  len_sat;
  logic        last_byte;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign len_sat    = (line_length_i > MaxLen) ? MaxLen : line_length_i;
  assign last_byte  = (left_q == 6'd1);

  always_comb begin
    pending_d = pending_q;
    cnt_d     = cnt_q;
    left_d    = left_q;
    push_o    = 1'b0;
    job_o     = '{mode: JOB_LEN, group: {18'd0, len_sat}, nl: (len_sat == 6'd0)};
    if (accept) begin
      if (kind_i == KindStart) begin
        pending_d = '0;
        cnt_d     = '0;
        left_d    = len_sat;
        push_o    = 1'b1;
      end else if (left_q != 6'd0) begin
        left_d    = left_q - 6'd1;
        job_o.mode = JOB_GROUP;
        job_o.nl   = last_byte;
        unique case (cnt_q)
          2'd2:    job_o.group = {pending_q, data_byte_i};
          2'd1:    job_o.group = {pending_q[7:0], data_byte_i, 8'd0};
          default: job_o.group = {data_byte_i, 16'd0};
        endcase
        if (cnt_q == 2'd2 || last_byte) begin
          push_o    = 1'b1;
          pending_d = '0;
          cnt_d     = '0;
        end else begin
          pending_d = {pending_q[7:0], data_byte_i};
          cnt_d     = cnt_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      cnt_q     <= '0;
      left_q    <= '0;
    end else begin
      pending_q <= pending_d;
      cnt_q     <= cnt_d;
      left_q    <= left_d;
    end
  end

endmodule

### hw/rtl/uule_queue.sv
// short job queue between front and back end
module uule_queue import uule_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output job_t head_o
);

  localparam int PtrW = $clog2(QueueDepth);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;

  assign full_o  = (count_q == (PtrW+1)'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + (PtrW+1)'(1);
        2'b01:   count_q <= count_q - (PtrW+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

### hw/rtl/uule_back.sv
// back end: turns jobs into characters, one per cycle while the receiver does not stall, into the output register
module uule_back import uule_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  job_t       head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       line_end_o
);

  logic       out_valid_q;
  logic [7:0] char_q;
  logic       end_q;
  logic [2:0] idx_q;
  logic [2:0] last_idx;
  logic       advance;
  logic       is_nl;
  logic [5:0] sextet;
  logic [7:0] next_char;

  assign last_idx = ((head_i.mode == JOB_LEN) ? 3'd0 : 3'd3) + {2'b00, head_i.nl};
  assign is_nl    = head_i.nl && (idx_q == last_idx);
  assign advance  = !q_empty_i && (!out_valid_q || !out_stall_i);
  assign pop_o    = advance && (idx_q == last_idx);

  always_comb begin
    if (head_i.mode == JOB_LEN) begin
      sextet = head_i.group[5:0];
    end else begin
      unique case (idx_q[1:0])
        2'd0:    sextet = head_i.group[23:18];
        2'd1:    sextet = head_i.group[17:12];
        2'd2:    sextet = head_i.group[11:6];
        default: sextet = head_i.group[5:0];
      endcase
    end
    next_char = is_nl ? NewlineChar : ({2'b00, sextet} + CharOffset);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
      idx_q       <= (idx_q == last_idx) ? 3'd0 : idx_q + 3'd1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      char_q <= next_char;
      end_q  <= is_nl;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = char_q;
  assign line_end_o  = end_q;

endmodule

### sim/testbench.sv
// testbench for the uuencode line encoder: directed table, then random lines checked by a predictor
module testbench import uule_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxLineBytes  = 45;
  localparam int RandomItems   = 125;
  localparam int HoldOffCycles = 80;
  localparam int HoldOffAt     = 10;
  localparam int IdleLimit     = 1000;
  localparam int DrainCycles   = 20;

  typedef struct packed {
    logic       line_end;
    logic [7:0] ch;
  } enc_char_t;

  typedef struct packed {
    logic                kind;
    logic [5:0]          len;
    logic [7:0]          data;
    logic                typed;
    logic [2:0]          n_typed;
    enc_char_t [4:0]     typed_chars;
  } stim_row_t;

  localparam enc_char_t SpaceChar  = '{1'b0, CharOffset};
  localparam enc_char_t NlChar     = '{1'b1, NewlineChar};
  localparam enc_char_t TopChar    = '{1'b0, CharOffset + 8'd63};
  localparam enc_char_t OneLenChar = '{1'b0, CharOffset + 8'd1};
  localparam enc_char_t MaxLenChar = '{1'b0, CharOffset + 8'(MaxLineBytes)};

  logic       clk_i;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_stall_o;
  logic       kind_i        = KindStart;
  logic [5:0] line_length_i = '0;
  logic [7:0] data_byte_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i   = 1'b0;
  logic [7:0] out_char_o;
  logic       line_end_o;

  // predictor state
  logic [15:0] held_bits;
  logic [1:0]  held_count;
  logic [5:0]  bytes_owed;

  enc_char_t   item_chars[$];
  enc_char_t   expected_chars[$];
  stim_row_t   directed_rows[$];
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  logic        in_burst = 1'b0;

  uuencode_line_encoder #(
    .MAX_LINE_BYTES(MaxLineBytes)
  ) dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .kind_i,
    .line_length_i,
    .data_byte_i,
    .out_valid_o,
    .out_stall_i,
    .out_char_o,
    .line_end_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic stim_row_t mk_row(input logic k, input logic [5:0] len,
                                       input logic [7:0] data, input logic typed = 1'b0,
                                       input int n = 0, input enc_char_t c0 = '0,
                                       input enc_char_t c1 = '0, input enc_char_t c2 = '0,
                                       input enc_char_t c3 = '0, input enc_char_t c4 = '0);
    stim_row_t r;
    r.kind        = k;
    r.len         = len;
    r.data        = data;
    r.typed       = typed;
    r.n_typed     = 3'(n);
    r.typed_chars = {c4, c3, c2, c1, c0};
    return r;
  endfunction

  function automatic void push_group(input logic [23:0] grp);
    for (int i = 0; i < 4; i++) begin
      item_chars.push_back('{1'b0, CharOffset + 8'(grp[23 - 6 * i -: 6])});
    end
  endfunction

  // characters caused by one item, left in item_chars
  function automatic void encode_item(input logic k, input logic [5:0] len,
                                      input logic [7:0] data);
    logic [5:0] n;
    item_chars.delete();
    if (k == KindStart) begin
      n = (len > MaxLineBytes) ? 6'(MaxLineBytes) : len;
      held_bits  = '0;
      held_count = '0;
      bytes_owed = n;
      item_chars.push_back('{1'b0, CharOffset + 8'(n)});
      if (n == 0) item_chars.push_back(NlChar);
      return;
    end
    if (bytes_owed == 0) return;
    bytes_owed = bytes_owed - 6'd1;
    if (held_count == 2'd2) begin
      push_group({held_bits, data});
      held_bits  = '0;
      held_count = '0;
    end else begin
      held_bits  = {held_bits[7:0], data};
      held_count = held_count + 2'd1;
    end
    if (bytes_owed == 0) begin
      if (held_count == 2'd1) push_group({held_bits[7:0], 16'h0000});
      else if (held_count == 2'd2) push_group({held_bits, 8'h00});
      held_bits  = '0;
      held_count = '0;
      item_chars.push_back(NlChar);
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic drive_item(input logic k, input logic [5:0] len, input logic [7:0] data);
    int gap;
    if ($urandom_range(0, 19) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= k;
    line_length_i <= len;
    data_byte_i   <= data;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_checked(input logic k, input logic [5:0] len, input logic [7:0] data);
    drive_item(k, len, data);
    encode_item(k, len, data);
    foreach (item_chars[i]) expected_chars.push_back(item_chars[i]);
  endtask

  initial begin
    stim_row_t  row;
    logic [5:0] len;
    int         n_send;
    int         rnd_items;
    held_bits  = '0;
    held_count = '0;
    bytes_owed = '0;
    // byte with no open line
    directed_rows.push_back(mk_row(KindByte, 6'd0, 8'hFF, 1'b1, 0));
    // empty line
    directed_rows.push_back(mk_row(KindStart, 6'd0, 8'h00, 1'b1, 2, SpaceChar, NlChar));
    // overlong line saturates
    directed_rows.push_back(mk_row(KindStart, 6'd63, 8'hFF, 1'b1, 1, MaxLenChar));
    directed_rows.push_back(mk_row(KindByte, 6'd0, 8'hFF));
    directed_rows.push_back(mk_row(KindByte, 6'd63, 8'h80));
    // start during a line drops the held bytes
    directed_rows.push_back(mk_row(KindStart, 6'd1, 8'h00, 1'b1, 1, OneLenChar));
    directed_rows.push_back(mk_row(KindByte, 6'd0, 8'h00, 1'b1, 5,
                                   SpaceChar, SpaceChar, SpaceChar, SpaceChar, NlChar));
    directed_rows.push_back(mk_row(KindStart, 6'd3, 8'hFF));
    directed_rows.push_back(mk_row(KindByte, 6'd0, 8'hFF));
    directed_rows.push_back(mk_row(KindByte, 6'd63, 8'hFF));
    directed_rows.push_back(mk_row(KindByte, 6'd0, 8'hFF, 1'b1, 5,
                                   TopChar, TopChar, TopChar, TopChar, NlChar));
    // byte after the line closed
    directed_rows.push_back(mk_row(KindByte, 6'd21, 8'h5A, 1'b1, 0));
    directed_rows.push_back(mk_row(KindStart, 6'd2, 8'h00));
    directed_rows.push_back(mk_row(KindByte, 6'd0, 8'hA5));
    directed_rows.push_back(mk_row(KindByte, 6'd42, 8'h3C));
    directed_rows.push_back(mk_row(KindStart, 6'd45, 8'h00, 1'b1, 1, MaxLenChar));
    directed_rows.push_back(mk_row(KindStart, 6'd4, 8'h55));
    directed_rows.push_back(mk_row(KindByte, 6'd0, 8'h01));
    directed_rows.push_back(mk_row(KindByte, 6'd0, 8'h02));
    directed_rows.push_back(mk_row(KindByte, 6'd0, 8'h03));
    directed_rows.push_back(mk_row(KindByte, 6'd0, 8'h04));
    directed_rows.push_back(mk_row(KindStart, 6'd46, 8'hAA));
    directed_rows.push_back(mk_row(KindStart, 6'd5, 8'h00));

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.typed) begin
        drive_item(row.kind, row.len, row.data);
        encode_item(row.kind, row.len, row.data);
        for (int j = 0; j < row.n_typed; j++) expected_chars.push_back(row.typed_chars[j]);
      end else begin
        send_checked(row.kind, row.len, row.data);
      end
    end

    rnd_items = 0;
    while (rnd_items < RandomItems) begin
      if ($urandom_range(0, 9) == 0) begin
        send_checked(KindByte, 6'($urandom), 8'($urandom));
        rnd_items++;
      end else begin
        len = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                          : 6'($urandom_range(0, 8));
        n_send = (len > MaxLineBytes) ? MaxLineBytes : int'(len);
        // some lines are cut short by the next start
        if ($urandom_range(0, 7) == 0) n_send = $urandom_range(0, n_send);
        send_checked(KindStart, len, 8'($urandom));
        repeat (n_send) send_checked(KindByte, 6'($urandom), 8'($urandom));
        rnd_items += n_send + 1;
      end
    end
    in_valid_i <= 1'b0;

    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("uuencode_line_encoder: match");
    end else begin
      $display("uuencode_line_encoder: mismatch");
    end
    $finish;
  end

  // receiver: random stalls, one long hold so the encoder backs up
  initial begin
    int   n;
    int   chars_taken;
    logic out_burst;
    chars_taken = 0;
    out_burst   = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 19) == 0) out_burst = !out_burst;
      n = out_burst ? 0 : $urandom_range(0, 11);
      if (chars_taken == HoldOffAt) n = HoldOffCycles;
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      chars_taken++;
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    enc_char_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("char with none expected", out_char_o, -1);
      end else begin
        want = expected_chars.pop_front();
        if (out_char_o !== want.ch) report_mismatch("out_char", out_char_o, want.ch);
        if (line_end_o !== want.line_end) begin
          report_mismatch("line_end", line_end_o, want.line_end);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IdleLimit) begin
      $display("%0t ns: no item moved for %0d cycles", $realtime, IdleLimit);
      $display("uuencode_line_encoder: mismatch");
      $finish;
    end
  end

endmodule
